// ----- hw/rtl/ptns_pkg.sv -----
// Shared types and constants for the point table nearest search block.
package ptns_pkg;

	// Table size and derived widths
	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > 6) ? CNT_W + 1 : 7;
	localparam int COORD_W  = 16;
	localparam int SQ_W     = 2 * COORD_W;
	localparam int DIST_W   = SQ_W + 1;

	typedef enum logic [2:0] {
		MODE_ADD     = 3'd0,
		MODE_REMOVE  = 3'd1,
		MODE_MOVE    = 3'd2,
		MODE_GET     = 3'd3,
		MODE_NEAREST = 3'd4
	} ptns_mode_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_BAD_INDEX  = 2'd1,
		STAT_FULL       = 2'd2,
		STAT_NEG_RADIUS = 2'd3
	} ptns_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GET,
		S_SCAN,
		S_SHIFT,
		S_FIN,
		S_RESP
	} ptns_state_t;

	typedef struct packed {
		logic [2:0]                mode;
		logic [5:0]                entry_index;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] search_radius;
	} ptns_req_t;

	typedef struct packed {
		ptns_status_t              status;
		logic [5:0]                result_index;
		logic                      found;
		logic                      inside_radius;
		logic signed [COORD_W-1:0] result_x;
		logic signed [COORD_W-1:0] result_y;
	} ptns_rsp_t;

endpackage

// ----- hw/rtl/ptns_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface ptns_req_if;
	logic              valid;
	logic              ready;
	ptns_pkg::ptns_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ptns_rsp_if;
	logic              valid;
	logic              ready;
	ptns_pkg::ptns_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/point_table_nearest_search.sv -----
// Point table with add/remove/move/get and linear-scan nearest search.
//
// Usage: one request on req (valid/ready, accepted when both are high) gives
// exactly one response on rsp. The block takes one request at a time: req.ready
// is high only while the sequencer is idle. A finished response sits in an
// output register, so a new request is taken while that response still waits.
// Steps per request:
//   add, move, unused modes, bad index, negative radius: straight to the response
//   get: the entry is read from the table, then the response is staged
//   nearest search: one entry per cycle goes through the single distance
//     unit (read, two squarers, compare), then the result is staged
//   remove: the table, with one write and one read port, moves one entry
//     down per cycle, from entry_index + 1 up to the last entry
// For search and remove, throughput is set by the one table read port and
// the one distance unit.
// Reset clears the entry count, the sequencer and the output valid flag; table
// contents need no clearing since only entries below the count are read.
// If the receiver stalls, the response holds on rsp and the next request runs
// up to its own response, then waits until the output register frees.
module point_table_nearest_search (
	input  logic clk,
	input  logic arst_n,
	ptns_req_if.sink   req,
	ptns_rsp_if.source rsp
);

	localparam int IDX_W   = ptns_pkg::IDX_W;
	localparam int CNT_W   = ptns_pkg::CNT_W;
	localparam int CMP_W   = ptns_pkg::CMP_W;
	localparam int COORD_W = ptns_pkg::COORD_W;
	localparam int SQ_W    = ptns_pkg::SQ_W;
	localparam int DIST_W  = ptns_pkg::DIST_W;

	ptns_pkg::ptns_state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_ptr_q;

	// point table
	logic [2*COORD_W-1:0] mem [ptns_pkg::CAPACITY];
	logic [2*COORD_W-1:0] mem_rd_q;

	// distance pipeline
	logic              v_s1, v_s2;
	logic [IDX_W-1:0]  idx_s1, idx_s2;
	logic [SQ_W-1:0]   sq_x_s2, sq_y_s2;
	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              found_q;
	logic signed [COORD_W-1:0] qx_q, qy_q;
	logic [SQ_W-1:0]   rad_sq_q;

	ptns_pkg::ptns_rsp_t res_q, res_d;
	ptns_pkg::ptns_rsp_t out_q;
	logic                out_valid_q;

	// control strobes
	logic                 accept;
	logic                 idx_ok;
	logic                 full;
	logic                 rd_issue;
	logic                 mem_we, mem_re;
	logic [IDX_W-1:0]     mem_wa, mem_ra;
	logic [2*COORD_W-1:0] mem_wd;
	logic                 load_out;
	logic                 cnt_inc, cnt_dec;
	logic                 start_scan, start_shift;
	logic                 res_we;

	// distance datapath signals
	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W-1:0]      ax, ay;
	logic [DIST_W-1:0]       dist_sum;
	logic [COORD_W-1:0]      rad_abs;

	assign accept   = req.valid && req.ready;
	assign idx_ok   = CMP_W'(req.data.entry_index) < CMP_W'(cnt_q);
	assign full     = cnt_q == CNT_W'(ptns_pkg::CAPACITY);
	assign rd_issue = rd_ptr_q < cnt_q;

	assign req.ready = state_q == ptns_pkg::S_IDLE;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptns_pkg::S_IDLE: begin
				if (accept) begin
					state_d = ptns_pkg::S_RESP;
					case (ptns_pkg::ptns_mode_t'(req.data.mode))
						ptns_pkg::MODE_REMOVE: begin
							if (idx_ok) state_d = ptns_pkg::S_SHIFT;
						end
						ptns_pkg::MODE_GET: begin
							if (idx_ok) state_d = ptns_pkg::S_GET;
						end
						ptns_pkg::MODE_NEAREST: begin
							if (!req.data.search_radius[COORD_W-1]) state_d = ptns_pkg::S_SCAN;
						end
						default: state_d = ptns_pkg::S_RESP;
					endcase
				end
			end
			ptns_pkg::S_GET: state_d = ptns_pkg::S_RESP;
			ptns_pkg::S_SCAN: begin
				if (!rd_issue && !v_s1 && !v_s2) state_d = ptns_pkg::S_FIN;
			end
			ptns_pkg::S_SHIFT: begin
				if (!rd_issue && !v_s1) state_d = ptns_pkg::S_RESP;
			end
			ptns_pkg::S_FIN: state_d = ptns_pkg::S_RESP;
			ptns_pkg::S_RESP: begin
				if (!out_valid_q || rsp.ready) state_d = ptns_pkg::S_IDLE;
			end
			default: state_d = ptns_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mem_we      = 1'b0;
		mem_wa      = '0;
		mem_wd      = '0;
		mem_re      = 1'b0;
		mem_ra      = rd_ptr_q[IDX_W-1:0];
		load_out    = 1'b0;
		cnt_inc     = 1'b0;
		cnt_dec     = 1'b0;
		start_scan  = 1'b0;
		start_shift = 1'b0;
		res_we      = 1'b0;
		res_d       = res_q;
		case (state_q)
			ptns_pkg::S_IDLE: begin
				if (accept) begin
					res_we = 1'b1;
					res_d  = '0;
					case (ptns_pkg::ptns_mode_t'(req.data.mode))
						ptns_pkg::MODE_ADD: begin
							if (full) begin
								res_d.status = ptns_pkg::STAT_FULL;
							end else begin
								mem_we  = 1'b1;
								mem_wa  = cnt_q[IDX_W-1:0];
								mem_wd  = {req.data.point_x, req.data.point_y};
								cnt_inc = 1'b1;
							end
						end
						ptns_pkg::MODE_REMOVE: begin
							if (idx_ok) start_shift = 1'b1;
							else res_d.status = ptns_pkg::STAT_BAD_INDEX;
						end
						ptns_pkg::MODE_MOVE: begin
							if (idx_ok) begin
								mem_we = 1'b1;
								mem_wa = IDX_W'(req.data.entry_index);
								mem_wd = {req.data.point_x, req.data.point_y};
							end else begin
								res_d.status = ptns_pkg::STAT_BAD_INDEX;
							end
						end
						ptns_pkg::MODE_GET: begin
							if (idx_ok) begin
								mem_re = 1'b1;
								mem_ra = IDX_W'(req.data.entry_index);
							end else begin
								res_d.status = ptns_pkg::STAT_BAD_INDEX;
							end
						end
						ptns_pkg::MODE_NEAREST: begin
							if (req.data.search_radius[COORD_W-1]) begin
								res_d.status = ptns_pkg::STAT_NEG_RADIUS;
							end else begin
								start_scan = 1'b1;
							end
						end
						default: res_d.status = ptns_pkg::STAT_OK;
					endcase
				end
			end
			ptns_pkg::S_GET: begin
				res_we     = 1'b1;
				res_d.result_x = mem_rd_q[2*COORD_W-1:COORD_W];
				res_d.result_y = mem_rd_q[COORD_W-1:0];
			end
			ptns_pkg::S_SCAN: begin
				mem_re = rd_issue;
			end
			ptns_pkg::S_SHIFT: begin
				mem_re = rd_issue;
				// entry read last cycle moves one place down
				if (v_s1) begin
					mem_we = 1'b1;
					mem_wa = idx_s1 - IDX_W'(1);
					mem_wd = mem_rd_q;
				end
				if (!rd_issue && !v_s1) cnt_dec = 1'b1;
			end
			ptns_pkg::S_FIN: begin
				res_we              = 1'b1;
				res_d.found         = found_q;
				// empty table reports index zero
				res_d.result_index  = found_q ? 6'(best_idx_q) : 6'd0;
				res_d.inside_radius = found_q && (best_q <= DIST_W'(rad_sq_q));
			end
			ptns_pkg::S_RESP: begin
				load_out = !out_valid_q || rsp.ready;
			end
			default: ;
		endcase
	end

	// state, count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptns_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) cnt_q <= cnt_q + CNT_W'(1);
			else if (cnt_dec) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start_scan) rd_ptr_q <= '0;
		else if (start_shift) rd_ptr_q <= CNT_W'(req.data.entry_index) + CNT_W'(1);
		else if (rd_issue && (state_q == ptns_pkg::S_SCAN || state_q == ptns_pkg::S_SHIFT))
			rd_ptr_q <= rd_ptr_q + CNT_W'(1);
	end

	// table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) mem_rd_q <= mem[mem_ra];
	end

	// squared distance unit, shared by every entry of a scan
	assign dx = {mem_rd_q[2*COORD_W-1], mem_rd_q[2*COORD_W-1:COORD_W]} - {qx_q[COORD_W-1], qx_q};
	assign dy = {mem_rd_q[COORD_W-1], mem_rd_q[COORD_W-1:0]} - {qy_q[COORD_W-1], qy_q};
	assign ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
	assign ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
	assign dist_sum = DIST_W'(sq_x_s2) + DIST_W'(sq_y_s2);
	assign rad_abs = req.data.search_radius;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ptns_pkg::S_SCAN || state_q == ptns_pkg::S_SHIFT) && rd_issue;
			v_s2 <= v_s1 && (state_q == ptns_pkg::S_SCAN);
			if (start_scan) found_q <= 1'b0;
			else if (v_s2) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_ptr_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		sq_x_s2 <= SQ_W'(ax * ax);
		sq_y_s2 <= SQ_W'(ay * ay);
		if (start_scan) begin
			qx_q     <= req.data.point_x;
			qy_q     <= req.data.point_y;
			rad_sq_q <= SQ_W'(rad_abs * rad_abs);
		end
		// first minimum wins on ties
		if (v_s2 && (!found_q || dist_sum < best_q)) begin
			best_q     <= dist_sum;
			best_idx_q <= idx_s2;
		end
	end

	// result staging and output register
	always_ff @(posedge clk) begin
		if (res_we) res_q <= res_d;
		if (load_out) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/ptns_checker.sv -----
// Port-level checks for the point table nearest search block, bound to the top.
module ptns_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input ptns_pkg::ptns_rsp_t rsp_data
);

	logic [1:0] pending_q;
	logic       req_acc, rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(req_acc) - 2'(rsp_acc);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("response changed while stalled");

	a_rsp_owed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response without an open request");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.found || rsp_data.inside_radius)
		|-> rsp_data.found && rsp_data.status == ptns_pkg::STAT_OK)
		else $error("search flags inconsistent with status");

endmodule

bind point_table_nearest_search ptns_checker u_ptns_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
